/* rtl/mer_pkg.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse raster package
// Widths, control word layout and the microprogram of the ellipse sequencer.
// ----------------------------------------------------------------------------
package mer_pkg;

	localparam int DEF_RADIUS_BITS = 10;
	localparam int DEF_COORD_BITS  = 13;
	localparam int CENTER_W        = 12;
	localparam int PC_W            = 5;

	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS_X = 2'd2,
		REG_RADIUS_Y = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_REGION1 = 4'b0010,
		PH_REGION2 = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	typedef enum logic [3:0] {
		MUL_NONE, MUL_RXRX, MUL_RYRY, MUL_RXSQ_RY, MUL_RYSQ_X, MUL_RXSQ_Y,
		MUL_RYSQ_TX, MUL_TX_TX, MUL_YD_YS, MUL_RXSQ_T, MUL_RYSQ_T
	} mul_sel_t;

	typedef enum logic [1:0] {XY_NONE, XY_INIT, XY_XINC, XY_YDEC} xy_op_t;

	typedef enum logic [2:0] {
		AUX_NONE, AUX_W_RXSQ, AUX_W_RYSQ, AUX_T_LOAD, AUX_FLAG_DNEG, AUX_FLAG_DLE0
	} aux_op_t;

	typedef enum logic [2:0] {
		D_NONE, D_START, D_ADD_SH2, D_SUB_SH3, D_LOAD_SH2, D_ADD, D_ADD_SH3, D_R2
	} d_op_t;

	typedef enum logic [1:0] {PHW_KEEP, PHW_START, PHW_R2, PHW_DONE} ph_op_t;

	typedef enum logic [2:0] {J_NONE, J_ALWAYS, J_R1FAIL, J_FLAG, J_NFLAG, J_YZERO} jmp_t;

	typedef enum logic [2:0] {EM_NONE, EM_Q0, EM_Q1, EM_Q2, EM_Q3, EM_FIN} emit_t;

	typedef struct packed {
		mul_sel_t         mul;
		xy_op_t           xy;
		aux_op_t          aux;
		d_op_t            dop;
		ph_op_t           ph;
		jmp_t             jmp;
		logic [PC_W-1:0]  target;
		emit_t            emit;
		logic             done;
	} uword_t;

	localparam logic [PC_W-1:0] A_START    = 5'd0;
	localparam logic [PC_W-1:0] A_S1       = 5'd1;
	localparam logic [PC_W-1:0] A_S2       = 5'd2;
	localparam logic [PC_W-1:0] A_S3       = 5'd3;
	localparam logic [PC_W-1:0] A_R1_TEST  = 5'd4;
	localparam logic [PC_W-1:0] A_R1_CMP   = 5'd5;
	localparam logic [PC_W-1:0] A_R1_BR    = 5'd6;
	localparam logic [PC_W-1:0] A_R1_STEP  = 5'd7;
	localparam logic [PC_W-1:0] A_R1_MX    = 5'd8;
	localparam logic [PC_W-1:0] A_R1_DX    = 5'd9;
	localparam logic [PC_W-1:0] A_R1_YDEC  = 5'd10;
	localparam logic [PC_W-1:0] A_R1_MY    = 5'd11;
	localparam logic [PC_W-1:0] A_R1_DY    = 5'd12;
	localparam logic [PC_W-1:0] A_R2_I0    = 5'd13;
	localparam logic [PC_W-1:0] A_R2_I1    = 5'd14;
	localparam logic [PC_W-1:0] A_R2_I2    = 5'd15;
	localparam logic [PC_W-1:0] A_R2_I3    = 5'd16;
	localparam logic [PC_W-1:0] A_R2_I4    = 5'd17;
	localparam logic [PC_W-1:0] A_R2       = 5'd18;
	localparam logic [PC_W-1:0] A_R2_TEST  = 5'd19;
	localparam logic [PC_W-1:0] A_R2_BR    = 5'd20;
	localparam logic [PC_W-1:0] A_R2_XINC  = 5'd21;
	localparam logic [PC_W-1:0] A_R2_MX    = 5'd22;
	localparam logic [PC_W-1:0] A_R2_DX    = 5'd23;
	localparam logic [PC_W-1:0] A_R2_MY    = 5'd24;
	localparam logic [PC_W-1:0] A_R2_DY    = 5'd25;
	localparam logic [PC_W-1:0] A_EMIT0    = 5'd26;
	localparam logic [PC_W-1:0] A_EMIT1    = 5'd27;
	localparam logic [PC_W-1:0] A_EMIT2    = 5'd28;
	localparam logic [PC_W-1:0] A_EMIT3    = 5'd29;
	localparam logic [PC_W-1:0] A_FIN      = 5'd30;

	localparam uword_t UW_NOP = '{
		mul: MUL_NONE, xy: XY_NONE, aux: AUX_NONE, dop: D_NONE, ph: PHW_KEEP,
		jmp: J_NONE, target: A_START, emit: EM_NONE, done: 1'b0
	};

	function automatic uword_t urom(input logic [PC_W-1:0] addr);
		uword_t w;
		w = UW_NOP;
		case (addr)
			A_START: begin
				w.mul = MUL_RXRX;
				w.xy  = XY_INIT;
			end
			A_S1: begin
				w.mul = MUL_RYRY;
				w.aux = AUX_W_RXSQ;
			end
			A_S2: begin
				w.mul = MUL_RXSQ_RY;
				w.aux = AUX_W_RYSQ;
			end
			A_S3: begin
				w.dop  = D_START;
				w.ph   = PHW_START;
				w.done = 1'b1;
			end
			A_R1_TEST: w.mul = MUL_RYSQ_X;
			A_R1_CMP: begin
				w.mul = MUL_RXSQ_Y;
				w.aux = AUX_T_LOAD;
			end
			A_R1_BR: begin
				w.jmp    = J_R1FAIL;
				w.target = A_R2_I0;
			end
			A_R1_STEP: begin
				w.aux = AUX_FLAG_DNEG;
				w.xy  = XY_XINC;
			end
			A_R1_MX: w.mul = MUL_RYSQ_TX;
			A_R1_DX: begin
				w.dop    = D_ADD_SH2;
				w.jmp    = J_FLAG;
				w.target = A_EMIT0;
			end
			A_R1_YDEC: w.xy = XY_YDEC;
			A_R1_MY: w.mul = MUL_RXSQ_Y;
			A_R1_DY: begin
				w.dop    = D_SUB_SH3;
				w.jmp    = J_ALWAYS;
				w.target = A_EMIT0;
			end
			A_R2_I0: w.mul = MUL_YD_YS;
			A_R2_I1: begin
				w.mul = MUL_TX_TX;
				w.aux = AUX_T_LOAD;
			end
			A_R2_I2: begin
				w.mul = MUL_RXSQ_T;
				w.aux = AUX_T_LOAD;
			end
			A_R2_I3: begin
				w.mul = MUL_RYSQ_T;
				w.dop = D_LOAD_SH2;
			end
			A_R2_I4: begin
				w.dop = D_ADD;
				w.ph  = PHW_R2;
			end
			A_R2: begin
				w.jmp    = J_YZERO;
				w.target = A_FIN;
			end
			A_R2_TEST: begin
				w.aux = AUX_FLAG_DLE0;
				w.xy  = XY_YDEC;
			end
			A_R2_BR: begin
				w.jmp    = J_NFLAG;
				w.target = A_R2_MY;
			end
			A_R2_XINC: w.xy = XY_XINC;
			A_R2_MX: w.mul = MUL_RYSQ_X;
			A_R2_DX: w.dop = D_ADD_SH3;
			A_R2_MY: w.mul = MUL_RXSQ_Y;
			A_R2_DY: w.dop = D_R2;
			A_EMIT0: w.emit = EM_Q0;
			A_EMIT1: w.emit = EM_Q1;
			A_EMIT2: w.emit = EM_Q2;
			A_EMIT3: begin
				w.emit = EM_Q3;
				w.done = 1'b1;
			end
			A_FIN: begin
				w.emit = EM_FIN;
				w.ph   = PHW_DONE;
				w.done = 1'b1;
			end
			default: w = UW_NOP;
		endcase
		return w;
	endfunction

endpackage

/* rtl/mer_tick_if.sv */
// ----------------------------------------------------------------------------
// Tick channel
// Valid/ready channel carrying one start-or-advance request per transaction.
// ----------------------------------------------------------------------------
interface mer_tick_if;
	logic valid;
	logic ready;
	logic start_req;

	modport source (output valid, output start_req, input ready);
	modport sink (input valid, input start_req, output ready);
endinterface

/* rtl/mer_pixel_if.sv */
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one plotted pixel or completion mark.
// ----------------------------------------------------------------------------
interface mer_pixel_if
	import mer_pkg::*;
#(
	parameter int COORD_BITS = DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         last;
	logic                         finished;

	modport source (output valid, output pixel_x, output pixel_y, output last,
		output finished, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input last,
		input finished, output ready);
endinterface

/* rtl/midpoint_ellipse_raster.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse raster
// Two-region midpoint ellipse stepper run by a small microprogram over one
// shared multiplier and a scaled integer decision accumulator.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  tick     in         start_req
//  pixel    out        pixel_x, pixel_y, last, finished
//  cfg      in         cfg_we, cfg_index, cfg_data
//
// A start transaction, a region 1 step, the region handover and a region 2
// step each run as a microprogram sequence over the single multiplier, and
// each region step ends by emitting its four pixels; a completion tick that
// ends region 2 first passes the y test of region 2.
// Every pixel cycle waits while the output register is full and not taken.
// Reset clears the configuration, the phase and the sequencer.
// ----------------------------------------------------------------------------
module midpoint_ellipse_raster
	import mer_pkg::*;
#(
	parameter int RADIUS_BITS = DEF_RADIUS_BITS,
	parameter int COORD_BITS  = DEF_COORD_BITS
) (
	input  logic clk,
	input  logic arst_n,
	mer_tick_if.sink tick,
	mer_pixel_if.source pixel,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [((RADIUS_BITS > CENTER_W) ? RADIUS_BITS : CENTER_W)-1:0] cfg_data
);

	localparam int R     = RADIUS_BITS;
	localparam int C     = COORD_BITS;
	localparam int XW    = R + 1;
	localparam int SQ_W  = 2 * R;
	localparam int MA_W  = 2 * R + 1;
	localparam int MB_W  = 2 * R + 8;
	localparam int P_W   = MA_W + MB_W;
	localparam int D_W   = 4 * R + 4;
	localparam int YDW   = R + 3;
	localparam int SW_A  = (C > CENTER_W + 1) ? C : CENTER_W + 1;
	localparam int SUM_W = (SW_A > R + 2) ? SW_A : R + 2;

	logic signed [CENTER_W-1:0] cfg_cx_q, cfg_cy_q;
	logic [R-1:0]               cfg_rx_q, cfg_ry_q;

	logic signed [CENTER_W-1:0] cx_q, cy_q;
	logic [R-1:0]               ry_q;
	logic [SQ_W-1:0]            rxsq_q, rysq_q;
	logic [XW-1:0]              x_q, y_q;
	logic [D_W-1:0]             d_q;
	logic signed [P_W-1:0]      t_q, prod_q;
	logic                       flag_q;
	phase_t                     phase_q;
	logic                       busy_q;
	logic [PC_W-1:0]            pc_q;

	logic                       out_valid_q;
	logic [C-1:0]               out_x_q, out_y_q;
	logic                       out_last_q, out_fin_q;

	uword_t                     uw;
	logic                       out_free, exec, take_jump;
	logic [XW:0]                tx;
	logic [YDW-1:0]             yd, ys;
	logic signed [MA_W-1:0]     mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic [D_W-1:0]             pd, rxsq4;
	logic [SUM_W-1:0]           cx_w, cy_w, x_w, y_w;
	logic [SUM_W-1:0]           xp, xm, yp, ym;

	assign uw       = urom(pc_q);
	assign out_free = !out_valid_q || pixel.ready;
	assign exec     = busy_q && ((uw.emit == EM_NONE) || out_free);

	assign tick.ready     = !busy_q;
	assign pixel.valid    = out_valid_q;
	assign pixel.pixel_x  = out_x_q;
	assign pixel.pixel_y  = out_y_q;
	assign pixel.last     = out_last_q;
	assign pixel.finished = out_fin_q;

	assign tx = {x_q, 1'b1};
	assign yd = YDW'(y_q) - YDW'(1) - YDW'(ry_q);
	assign ys = YDW'(y_q) - YDW'(1) + YDW'(ry_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (uw.mul)
			MUL_RXRX: begin
				mul_a = MA_W'(cfg_rx_q);
				mul_b = MB_W'(cfg_rx_q);
			end
			MUL_RYRY: begin
				mul_a = MA_W'(cfg_ry_q);
				mul_b = MB_W'(cfg_ry_q);
			end
			MUL_RXSQ_RY: begin
				mul_a = MA_W'(rxsq_q);
				mul_b = MB_W'(ry_q);
			end
			MUL_RYSQ_X: begin
				mul_a = MA_W'(rysq_q);
				mul_b = MB_W'(x_q);
			end
			MUL_RXSQ_Y: begin
				mul_a = MA_W'(rxsq_q);
				mul_b = MB_W'(y_q);
			end
			MUL_RYSQ_TX: begin
				mul_a = MA_W'(rysq_q);
				mul_b = MB_W'(tx);
			end
			MUL_TX_TX: begin
				mul_a = MA_W'(tx);
				mul_b = MB_W'(tx);
			end
			MUL_YD_YS: begin
				mul_a = MA_W'($signed(yd));
				mul_b = MB_W'($signed(ys));
			end
			MUL_RXSQ_T: begin
				mul_a = MA_W'(rxsq_q);
				mul_b = t_q[MB_W-1:0];
			end
			MUL_RYSQ_T: begin
				mul_a = MA_W'(rysq_q);
				mul_b = t_q[MB_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign pd    = prod_q[D_W-1:0];
	assign rxsq4 = D_W'({rxsq_q, 2'b00});

	always_comb begin
		case (uw.jmp)
			J_ALWAYS: take_jump = 1'b1;
			J_R1FAIL: take_jump = (t_q > prod_q);
			J_FLAG:   take_jump = flag_q;
			J_NFLAG:  take_jump = !flag_q;
			J_YZERO:  take_jump = (y_q == '0);
			default:  take_jump = 1'b0;
		endcase
	end

	assign cx_w = SUM_W'(cx_q);
	assign cy_w = SUM_W'(cy_q);
	assign x_w  = SUM_W'(x_q);
	assign y_w  = SUM_W'(y_q);
	assign xp   = cx_w + x_w;
	assign xm   = cx_w - x_w;
	assign yp   = cy_w + y_w;
	assign ym   = cy_w - y_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cx_q <= '0;
			cfg_cy_q <= '0;
			cfg_rx_q <= '0;
			cfg_ry_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X: cfg_cx_q <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y: cfg_cy_q <= cfg_data[CENTER_W-1:0];
				REG_RADIUS_X: cfg_rx_q <= cfg_data[R-1:0];
				REG_RADIUS_Y: cfg_ry_q <= cfg_data[R-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pc_q    <= A_START;
			phase_q <= PH_IDLE;
		end else begin
			if (tick.valid && !busy_q) begin
				if (tick.start_req) begin
					busy_q <= 1'b1;
					pc_q   <= A_START;
				end else begin
					case (phase_q)
						PH_REGION1: begin
							busy_q <= 1'b1;
							pc_q   <= A_R1_TEST;
						end
						PH_REGION2: begin
							busy_q <= 1'b1;
							pc_q   <= A_R2;
						end
						PH_DONE: begin
							busy_q <= 1'b1;
							pc_q   <= A_FIN;
						end
						default: busy_q <= 1'b0;
					endcase
				end
			end else if (exec) begin
				pc_q <= take_jump ? uw.target : pc_q + PC_W'(1);
				if (uw.done) begin
					busy_q <= 1'b0;
				end
				case (uw.ph)
					PHW_START: phase_q <= (ry_q == '0) ? PH_DONE : PH_REGION1;
					PHW_R2:    phase_q <= PH_REGION2;
					PHW_DONE:  phase_q <= PH_DONE;
					default:   phase_q <= phase_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			if (uw.mul != MUL_NONE) begin
				prod_q <= mul_a * mul_b;
			end
			case (uw.xy)
				XY_INIT: begin
					x_q  <= '0;
					y_q  <= XW'(cfg_ry_q);
					ry_q <= cfg_ry_q;
					cx_q <= cfg_cx_q;
					cy_q <= cfg_cy_q;
				end
				XY_XINC: x_q <= x_q + XW'(1);
				XY_YDEC: y_q <= y_q - XW'(1);
				default: ;
			endcase
			case (uw.aux)
				AUX_W_RXSQ:    rxsq_q <= prod_q[SQ_W-1:0];
				AUX_W_RYSQ:    rysq_q <= prod_q[SQ_W-1:0];
				AUX_T_LOAD:    t_q    <= prod_q;
				AUX_FLAG_DNEG: flag_q <= d_q[D_W-1];
				AUX_FLAG_DLE0: flag_q <= d_q[D_W-1] || (d_q == '0);
				default: ;
			endcase
			case (uw.dop)
				D_START:    d_q <= D_W'({rysq_q, 2'b00}) + D_W'(rxsq_q)
					- {pd[D_W-3:0], 2'b00};
				D_ADD_SH2:  d_q <= d_q + {pd[D_W-3:0], 2'b00};
				D_SUB_SH3:  d_q <= d_q - {pd[D_W-4:0], 3'b000};
				D_LOAD_SH2: d_q <= {pd[D_W-3:0], 2'b00};
				D_ADD:      d_q <= d_q + pd;
				D_ADD_SH3:  d_q <= d_q + {pd[D_W-4:0], 3'b000};
				D_R2:       d_q <= d_q + rxsq4 - {pd[D_W-4:0], 3'b000};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec && (uw.emit != EM_NONE)) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			case (uw.emit)
				EM_Q0: begin
					out_x_q    <= xp[C-1:0];
					out_y_q    <= yp[C-1:0];
					out_last_q <= 1'b0;
					out_fin_q  <= 1'b0;
				end
				EM_Q1: begin
					out_x_q    <= xp[C-1:0];
					out_y_q    <= ym[C-1:0];
					out_last_q <= 1'b0;
					out_fin_q  <= 1'b0;
				end
				EM_Q2: begin
					out_x_q    <= xm[C-1:0];
					out_y_q    <= yp[C-1:0];
					out_last_q <= 1'b0;
					out_fin_q  <= 1'b0;
				end
				EM_Q3: begin
					out_x_q    <= xm[C-1:0];
					out_y_q    <= ym[C-1:0];
					out_last_q <= 1'b1;
					out_fin_q  <= 1'b0;
				end
				EM_FIN: begin
					out_x_q    <= '0;
					out_y_q    <= '0;
					out_last_q <= 1'b1;
					out_fin_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule
